/* rtl/ssdcs_pkg.sv */
// ----------------------------------------------------------------------------
// ssdcs_pkg
// Shared types, command constants and the segment table of the display
// command sequencer.
// ----------------------------------------------------------------------------
package ssdcs_pkg;

    localparam int QueueDepth = 2;

    localparam logic [7:0] CMD_DATA  = 8'h40;
    localparam logic [7:0] CMD_DISP  = 8'h80;
    localparam logic [7:0] CMD_ADDR  = 8'hC0;
    localparam logic [7:0] DASH_SEG  = 8'h40;
    localparam logic [7:0] POINT_BIT = 8'h80;
    localparam logic [7:0] ON_BIT    = 8'h08;
    localparam logic [9:0] MAG_MAX   = 10'd999;
    localparam logic [3:0] DIGIT_MAX = 4'd9;

    localparam logic [1:0] REG_BRIGHTNESS  = 2'd0;
    localparam logic [1:0] REG_DISPLAY_ON  = 2'd1;
    localparam logic [1:0] REG_POINT_PLACE = 2'd2;

    typedef enum logic [1:0] {
        ACT_CTRL  = 2'd0,
        ACT_DASH  = 2'd1,
        ACT_INT   = 2'd2,
        ACT_FIXED = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        PH_DATA,
        PH_ADDR,
        PH_SEG
    } phase_t;

    typedef struct packed {
        logic [2:0] brightness;
        logic       display_on;
        logic [1:0] point_place;
    } cfg_t;

    typedef struct packed {
        logic [7:0] seg;
        logic [1:0] pos;
    } sym_t;

    typedef struct packed {
        logic           ctrl;
        logic [7:0]     ctrl_byte;
        logic [1:0]     last_sym;
        sym_t [3:0]     syms;
    } plan_t;

    function automatic logic [7:0] seg_code(input logic [3:0] digit);
        logic [7:0] code;
        case (digit)
            4'd0: code = 8'h3F;
            4'd1: code = 8'h06;
            4'd2: code = 8'h5B;
            4'd3: code = 8'h4F;
            4'd4: code = 8'h66;
            4'd5: code = 8'h6D;
            4'd6: code = 8'h7D;
            4'd7: code = 8'h07;
            4'd8: code = 8'h7F;
            4'd9: code = 8'h6F;
            default: code = 8'h00;
        endcase
        return code;
    endfunction

endpackage

/* rtl/ssdcs_front.sv */
// ----------------------------------------------------------------------------
// ssdcs_front
// Takes requests, saturates the magnitude, splits it into decimal digits over
// two register stages and classifies the request into a plan of symbols.
// ----------------------------------------------------------------------------
module ssdcs_front
    import ssdcs_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  cfg_t        cfg,
    input  logic        in_valid,
    output logic        in_ready,
    input  action_t     in_action,
    input  logic [15:0] in_value,
    input  logic [3:0]  in_frac,
    output logic        plan_valid,
    input  logic        plan_ready,
    output plan_t       plan
);

    logic        in_neg;
    logic [15:0] in_abs;
    logic [9:0]  in_mag;
    logic [3:0]  in_frac_sat;

    logic        s1_valid_reg;
    action_t     s1_action_reg;
    logic        s1_neg_reg;
    logic [9:0]  s1_mag_reg;
    logic [3:0]  s1_frac_reg;

    logic [15:0] s1_prod;
    logic [3:0]  s1_hund;
    logic [10:0] s1_hund_x100;
    logic [10:0] s1_rem_full;

    logic        s2_valid_reg;
    action_t     s2_action_reg;
    logic        s2_neg_reg;
    logic [3:0]  s2_frac_reg;
    logic [3:0]  s2_hund_reg;
    logic [6:0]  s2_rem_reg;

    logic [14:0] s2_prod;
    logic [3:0]  s2_tens;
    logic [6:0]  s2_tens_x10;
    logic [6:0]  s2_ones_full;
    logic [3:0]  s2_ones;

    logic        s1_move;
    logic        s2_free;

    assign in_neg      = in_value[15];
    assign in_abs      = in_neg ? (16'd0 - in_value) : in_value;
    assign in_mag      = (in_abs > 16'(MAG_MAX)) ? MAG_MAX : in_abs[9:0];
    assign in_frac_sat = (in_frac > DIGIT_MAX) ? DIGIT_MAX : in_frac;

    assign s2_free  = !s2_valid_reg || plan_ready;
    assign s1_move  = s1_valid_reg && s2_free;
    assign in_ready = !s1_valid_reg || s2_free;

    // hundreds by reciprocal, exact below one thousand
    assign s1_prod      = 16'(s1_mag_reg) * 16'd41;
    assign s1_hund      = s1_prod[15:12];
    assign s1_hund_x100 = {1'b0, s1_hund, 6'b0} + {2'b0, s1_hund, 5'b0} + {5'b0, s1_hund, 2'b0};
    assign s1_rem_full  = {1'b0, s1_mag_reg} - s1_hund_x100;

    // tens by reciprocal, exact below one hundred
    assign s2_prod      = 15'(s2_rem_reg) * 15'd205;
    assign s2_tens      = s2_prod[14:11];
    assign s2_tens_x10  = {s2_tens, 3'b0} + {2'b0, s2_tens, 1'b0};
    assign s2_ones_full = s2_rem_reg - s2_tens_x10;
    assign s2_ones      = s2_ones_full[3:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end else begin
            if (in_ready) begin
                s1_valid_reg <= in_valid;
            end
            if (s2_free) begin
                s2_valid_reg <= s1_move;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            s1_action_reg <= in_action;
            s1_neg_reg    <= in_neg;
            s1_mag_reg    <= in_mag;
            s1_frac_reg   <= in_frac_sat;
        end
        if (s1_move) begin
            s2_action_reg <= s1_action_reg;
            s2_neg_reg    <= s1_neg_reg;
            s2_frac_reg   <= s1_frac_reg;
            s2_hund_reg   <= s1_hund;
            s2_rem_reg    <= s1_rem_full[6:0];
        end
    end

    always_comb begin
        logic [7:0] seg_h;
        logic [7:0] seg_t;
        logic [7:0] seg_o;
        logic [7:0] seg_f;
        seg_h = seg_code(s2_hund_reg);
        seg_t = seg_code(s2_tens);
        seg_o = seg_code(s2_ones);
        seg_f = seg_code(s2_frac_reg);

        plan.ctrl      = 1'b0;
        plan.ctrl_byte = CMD_DISP | (cfg.display_on ? ON_BIT : 8'h00)
                         | {5'b0, cfg.brightness};
        plan.last_sym  = 2'd2;
        plan.syms[3]   = '{seg: seg_f, pos: 2'd3};
        plan.syms[0]   = '{seg: DASH_SEG, pos: 2'd2};
        plan.syms[1]   = '{seg: DASH_SEG, pos: 2'd1};
        plan.syms[2]   = '{seg: DASH_SEG, pos: 2'd0};

        case (s2_action_reg)
            ACT_CTRL: begin
                plan.ctrl = 1'b1;
            end
            ACT_DASH: begin
                plan.last_sym = 2'd2;
            end
            ACT_INT: begin
                if (s2_neg_reg) begin
                    plan.syms[0] = '{seg: DASH_SEG, pos: 2'd0};
                    plan.syms[1] = '{seg: seg_o, pos: 2'd2};
                    plan.syms[2] = '{seg: seg_t, pos: 2'd1};
                end else begin
                    plan.syms[0] = '{seg: seg_o, pos: 2'd2};
                    plan.syms[1] = '{seg: seg_t, pos: 2'd1};
                    plan.syms[2] = '{seg: seg_h, pos: 2'd0};
                end
            end
            ACT_FIXED: begin
                if (s2_hund_reg != 4'd0) begin
                    plan.last_sym = 2'd3;
                    plan.syms[0]  = '{seg: seg_h, pos: 2'd0};
                    plan.syms[1]  = '{seg: seg_t, pos: 2'd1};
                    plan.syms[2]  = '{seg: seg_o, pos: 2'd2};
                end else begin
                    plan.syms[0] = '{seg: seg_t | ((cfg.point_place == 2'd2) ? POINT_BIT : 8'h00),
                                     pos: 2'd0};
                    plan.syms[1] = '{seg: seg_o | ((cfg.point_place == 2'd1) ? POINT_BIT : 8'h00),
                                     pos: 2'd1};
                    plan.syms[2] = '{seg: seg_f, pos: 2'd2};
                end
            end
            default: begin
                plan.ctrl = 1'b1;
            end
        endcase
    end

    assign plan_valid = s2_valid_reg;

endmodule

/* rtl/ssdcs_queue.sv */
// ----------------------------------------------------------------------------
// ssdcs_queue
// Short first-in first-out queue of plans between the front and back parts.
// ----------------------------------------------------------------------------
module ssdcs_queue
    import ssdcs_pkg::*;
#(
    parameter int DEPTH = QueueDepth
) (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  in_valid,
    output logic  in_ready,
    input  plan_t in_plan,
    output logic  out_valid,
    input  logic  out_ready,
    output plan_t out_plan
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    plan_t         store_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg;
    logic [AW-1:0] rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic          push;
    logic          pop;

    assign in_ready  = count_reg != FULL_CNT;
    assign out_valid = count_reg != '0;
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_plan  = store_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + AW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + AW'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + CW'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            store_reg[wr_ptr_reg] <= in_plan;
        end
    end

endmodule

/* rtl/ssdcs_back.sv */
// ----------------------------------------------------------------------------
// ssdcs_back
// Walks the head plan one bus byte per cycle, unless stalled, into a register.
// ----------------------------------------------------------------------------
module ssdcs_back
    import ssdcs_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       plan_valid,
    output logic       plan_ready,
    input  plan_t      plan,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       out_start,
    output logic       out_stop,
    output logic       out_last
);

    phase_t     phase_reg;
    phase_t     phase_next;
    logic [1:0] sym_idx_reg;
    logic [1:0] sym_idx_next;

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;
    logic [7:0] byte_next;
    logic       start_reg;
    logic       start_next;
    logic       stop_reg;
    logic       stop_next;
    logic       last_reg;
    logic       last_next;

    logic       load;
    sym_t       sym;

    assign load = !valid_reg || out_ready;
    assign sym  = plan.syms[sym_idx_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_DATA;
            sym_idx_reg <= '0;
            valid_reg   <= 1'b0;
        end else begin
            phase_reg   <= phase_next;
            sym_idx_reg <= sym_idx_next;
            valid_reg   <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        byte_reg  <= byte_next;
        start_reg <= start_next;
        stop_reg  <= stop_next;
        last_reg  <= last_next;
    end

    always_comb begin
        phase_next   = phase_reg;
        sym_idx_next = sym_idx_reg;
        valid_next   = valid_reg;
        byte_next    = byte_reg;
        start_next   = start_reg;
        stop_next    = stop_reg;
        last_next    = last_reg;
        plan_ready   = 1'b0;

        if (load) begin
            valid_next = plan_valid;
            if (plan_valid) begin
                if (plan.ctrl) begin
                    byte_next  = plan.ctrl_byte;
                    start_next = 1'b1;
                    stop_next  = 1'b1;
                    last_next  = 1'b1;
                    plan_ready = 1'b1;
                end else begin
                    case (phase_reg)
                        PH_DATA: begin
                            byte_next  = CMD_DATA;
                            start_next = 1'b1;
                            stop_next  = 1'b1;
                            last_next  = 1'b0;
                            phase_next = PH_ADDR;
                        end
                        PH_ADDR: begin
                            byte_next  = CMD_ADDR | {6'b0, sym.pos};
                            start_next = 1'b1;
                            stop_next  = 1'b0;
                            last_next  = 1'b0;
                            phase_next = PH_SEG;
                        end
                        PH_SEG: begin
                            byte_next  = sym.seg;
                            start_next = 1'b0;
                            stop_next  = 1'b1;
                            last_next  = sym_idx_reg == plan.last_sym;
                            phase_next = PH_DATA;
                            if (sym_idx_reg == plan.last_sym) begin
                                sym_idx_next = '0;
                                plan_ready   = 1'b1;
                            end else begin
                                sym_idx_next = sym_idx_reg + 2'd1;
                            end
                        end
                        default: begin
                            phase_next   = PH_DATA;
                            sym_idx_next = '0;
                            valid_next   = 1'b0;
                        end
                    endcase
                end
            end
        end
    end

    assign out_valid = valid_reg;
    assign out_byte  = byte_reg;
    assign out_start = start_reg;
    assign out_stop  = stop_reg;
    assign out_last  = last_reg;

endmodule

/* rtl/seven_segment_display_command_sequencer.sv */
// ----------------------------------------------------------------------------
// seven_segment_display_command_sequencer
// Turns display requests into framed command byte runs for a four-digit
// seven-segment driver chip.
// ----------------------------------------------------------------------------
// One bus byte leaves per cycle unless the bus stalls: a control request is one
// byte, dashes, integers and short fixed values are 9, a three-digit fixed value 12.
// The byte walker in the back part sets that rate; the front part accepts a
// new request every cycle while the plan queue has room, and a taken request
// passes the two front stages, the plan queue and the byte register in turn.
// ----------------------------------------------------------------------------
module seven_segment_display_command_sequencer
    import ssdcs_pkg::*;
#(
    parameter int QUEUE_DEPTH = QueueDepth
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [2:0]  cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // value[15:0], frac_digit[19:16], zero
    input  logic [1:0]  s_tuser,   // action[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // bus_byte[7:0]
    output logic [1:0]  m_tuser,   // start_before[0], stop_after[1]
    output logic        m_tlast
);

    cfg_t  cfg_reg;
    logic  fq_valid;
    logic  fq_ready;
    plan_t fq_plan;
    logic  qb_valid;
    logic  qb_ready;
    plan_t qb_plan;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.brightness  <= 3'd2;
            cfg_reg.display_on  <= 1'b1;
            cfg_reg.point_place <= 2'd1;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_BRIGHTNESS:  cfg_reg.brightness  <= cfg_data;
                REG_DISPLAY_ON:  cfg_reg.display_on  <= cfg_data[0];
                REG_POINT_PLACE: cfg_reg.point_place <= cfg_data[1:0];
                default: begin
                end
            endcase
        end
    end

    ssdcs_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_action  (action_t'(s_tuser)),
        .in_value   (s_tdata[15:0]),
        .in_frac    (s_tdata[19:16]),
        .plan_valid (fq_valid),
        .plan_ready (fq_ready),
        .plan       (fq_plan)
    );

    ssdcs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_plan   (fq_plan),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_plan  (qb_plan)
    );

    ssdcs_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .plan_valid (qb_valid),
        .plan_ready (qb_ready),
        .plan       (qb_plan),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_byte   (m_tdata),
        .out_start  (m_tuser[0]),
        .out_stop   (m_tuser[1]),
        .out_last   (m_tlast)
    );

endmodule
